>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/ragmt_pkg.sv
// Shared constants and types of the range add / global max tree.
package ragmt_pkg;
    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 48;
    localparam int CFG_BITS       = 11;
    localparam int IDX_BITS       = 10;
    localparam int DELTA_BITS     = 32;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;

    typedef enum logic {
        KIND_CLEAR = 1'b0,
        KIND_ADD   = 1'b1
    } kind_t;

    typedef enum logic {
        PH_LEFT  = 1'b0,
        PH_RIGHT = 1'b1
    } phase_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic range_ok;
        logic delta_sat;
    } walk_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic sat;
    } walk_stat_t;
endpackage

>>> rtl/ragmt_node_ram.sv
// Node memory: one write port, one registered read port.
module ragmt_node_ram #(
    parameter int DEPTH = 4 * ragmt_pkg::LEAVES_DEF,
    parameter int WIDTH = 2 * ragmt_pkg::VALUE_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> rtl/ragmt_walker.sv
// Tree walker: clearing sweep and depth-first lazy range add over the node memory.
module ragmt_walker #(
    parameter int LEAVES     = ragmt_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = ragmt_pkg::VALUE_BITS_DEF,
    localparam int DEPTH  = 4 * LEAVES,
    localparam int NODE_W = $clog2(DEPTH),
    localparam int LEAF_W = $clog2(LEAVES),
    localparam int V      = VALUE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ragmt_pkg::walk_cmd_t          cmd,
    input  logic                          take,
    input  logic [LEAF_W-1:0]             top_hi,
    input  logic [ragmt_pkg::IDX_BITS-1:0] left_idx,
    input  logic [ragmt_pkg::IDX_BITS-1:0] right_idx,
    input  logic signed [V-1:0]           delta_v,
    output ragmt_pkg::walk_stat_t         stat,
    output logic signed [V-1:0]           root_max,
    output logic                          ram_we,
    output logic [NODE_W-1:0]             ram_waddr,
    output logic [2*V-1:0]                ram_wdata,
    output logic                          ram_re,
    output logic [NODE_W-1:0]             ram_raddr,
    input  logic [2*V-1:0]                ram_rdata
);
    localparam int CW    = (LEAF_W > ragmt_pkg::IDX_BITS) ? LEAF_W : ragmt_pkg::IDX_BITS;
    localparam int STK_D = 2 ** $clog2(LEAF_W + 1);
    localparam int IX_W  = $clog2(STK_D);

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_VISIT   = 14'b00000000000100,
        ST_EVAL    = 14'b00000000001000,
        ST_PD_A    = 14'b00000000010000,
        ST_PD_B    = 14'b00000000100000,
        ST_PD_Z    = 14'b00000001000000,
        ST_DESCEND = 14'b00000010000000,
        ST_RET     = 14'b00000100000000,
        ST_MX_A    = 14'b00001000000000,
        ST_MX_B    = 14'b00010000000000,
        ST_ROOT    = 14'b00100000000000,
        ST_ROOT_W  = 14'b01000000000000,
        ST_DONE    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [LEAF_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [V-1:0] pend_reg, pend_next, nmax_reg, nmax_next, amax_reg, amax_next;
    logic signed [V-1:0] root_reg, root_next;
    logic sat_reg, sat_next, item_reg, item_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic [IX_W:0] sp_reg, sp_next;

    logic [NODE_W-1:0]   stk_node [STK_D];
    logic [LEAF_W-1:0]   stk_lo   [STK_D];
    logic [LEAF_W-1:0]   stk_hi   [STK_D];
    ragmt_pkg::phase_t   stk_ph   [STK_D];

    logic push_en, set_right;
    ragmt_pkg::phase_t push_ph;
    logic [IX_W-1:0] tos;
    logic [NODE_W-1:0] fnode, child_a, child_b;
    logic [LEAF_W-1:0] flo, fhi, mid, fmid;
    logic signed [V-1:0] rmax, rpend;
    logic [2*V:0] app;
    logic covered;

    // Saturating add: {flag, sum}.
    function automatic logic [V:0] sat_add(input logic signed [V-1:0] a,
                                           input logic signed [V-1:0] b);
        logic [V:0] s;
        logic [V:0] res;
        s = {a[V-1], a} + {b[V-1], b};
        if (s[V] != s[V-1]) begin
            res = {1'b1, s[V], {(V-1){~s[V]}}};
        end else begin
            res = {1'b0, s[V-1:0]};
        end
        return res;
    endfunction

    // Add to a node entry {max, pending}: {flag, entry}.
    function automatic logic [2*V:0] apply_add(input logic [2*V-1:0] e,
                                               input logic signed [V-1:0] d);
        logic [V:0] m;
        logic [V:0] p;
        m = sat_add(e[2*V-1:V], d);
        p = sat_add(e[V-1:0], d);
        return {m[V] | p[V], m[V-1:0], p[V-1:0]};
    endfunction

    assign rmax    = ram_rdata[2*V-1:V];
    assign rpend   = ram_rdata[V-1:0];
    assign child_a = {node_reg[NODE_W-2:0], 1'b0};
    assign child_b = {node_reg[NODE_W-2:0], 1'b1};
    assign mid     = LEAF_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign tos     = sp_reg[IX_W-1:0] - 1'b1;
    assign fnode   = stk_node[tos];
    assign flo     = stk_lo[tos];
    assign fhi     = stk_hi[tos];
    assign fmid    = LEAF_W'(({1'b0, flo} + {1'b0, fhi}) >> 1);
    assign covered = (CW'(left_idx) <= CW'(lo_reg)) && (CW'(hi_reg) <= CW'(right_idx));

    always_comb begin
        state_next = state_reg;
        node_next  = node_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pend_next  = pend_reg;
        nmax_next  = nmax_reg;
        amax_next  = amax_reg;
        root_next  = root_reg;
        sat_next   = sat_reg;
        item_next  = item_reg;
        clr_next   = clr_reg;
        sp_next    = sp_reg;
        push_en    = 1'b0;
        push_ph    = ragmt_pkg::PH_LEFT;
        set_right  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = node_reg;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = node_reg;
        app        = apply_add(ram_rdata, delta_v);
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = item_reg ? ST_ROOT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd.start) begin
                    item_next = 1'b1;
                    sat_next  = cmd.delta_sat;
                    node_next = NODE_W'(1);
                    lo_next   = '0;
                    hi_next   = top_hi;
                    sp_next   = '0;
                    if (cmd.clear) begin
                        state_next = ST_CLEAR;
                    end else if (cmd.range_ok) begin
                        state_next = ST_VISIT;
                    end else begin
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_VISIT: begin
                ram_re     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (covered) begin
                    ram_we     = 1'b1;
                    ram_wdata  = app[2*V-1:0];
                    sat_next   = sat_reg | app[2*V];
                    state_next = ST_RET;
                end else if (node_reg[NODE_W-1]) begin
                    state_next = ST_RET;
                end else begin
                    nmax_next = rmax;
                    pend_next = rpend;
                    if (rpend != '0) begin
                        ram_re     = 1'b1;
                        ram_raddr  = child_a;
                        state_next = ST_PD_A;
                    end else begin
                        state_next = ST_DESCEND;
                    end
                end
            end
            ST_PD_A: begin
                // Push the pending add into the left child, fetch the right one.
                app        = apply_add(ram_rdata, pend_reg);
                ram_we     = 1'b1;
                ram_waddr  = child_a;
                ram_wdata  = app[2*V-1:0];
                sat_next   = sat_reg | app[2*V];
                ram_re     = 1'b1;
                ram_raddr  = child_b;
                state_next = ST_PD_B;
            end
            ST_PD_B: begin
                app        = apply_add(ram_rdata, pend_reg);
                ram_we     = 1'b1;
                ram_waddr  = child_b;
                ram_wdata  = app[2*V-1:0];
                sat_next   = sat_reg | app[2*V];
                state_next = ST_PD_Z;
            end
            ST_PD_Z: begin
                ram_we     = 1'b1;
                ram_wdata  = {nmax_reg, {V{1'b0}}};
                state_next = ST_DESCEND;
            end
            ST_DESCEND: begin
                push_en = 1'b1;
                sp_next = sp_reg + 1'b1;
                if (CW'(left_idx) <= CW'(mid)) begin
                    push_ph   = ragmt_pkg::PH_LEFT;
                    node_next = child_a;
                    hi_next   = mid;
                end else begin
                    push_ph   = ragmt_pkg::PH_RIGHT;
                    node_next = child_b;
                    lo_next   = mid + 1'b1;
                end
                state_next = ST_VISIT;
            end
            ST_RET: begin
                if (sp_reg == '0) begin
                    state_next = ST_ROOT;
                end else if (stk_ph[tos] == ragmt_pkg::PH_LEFT &&
                             CW'(right_idx) > CW'(fmid)) begin
                    set_right  = 1'b1;
                    node_next  = {fnode[NODE_W-2:0], 1'b1};
                    lo_next    = fmid + 1'b1;
                    hi_next    = fhi;
                    state_next = ST_VISIT;
                end else begin
                    sp_next    = sp_reg - 1'b1;
                    node_next  = fnode;
                    ram_re     = 1'b1;
                    ram_raddr  = {fnode[NODE_W-2:0], 1'b0};
                    state_next = ST_MX_A;
                end
            end
            ST_MX_A: begin
                amax_next  = rmax;
                ram_re     = 1'b1;
                ram_raddr  = child_b;
                state_next = ST_MX_B;
            end
            ST_MX_B: begin
                // Pending of this node is zero here: it was pushed down on the way in.
                ram_we     = 1'b1;
                ram_wdata  = {(amax_reg > rmax) ? amax_reg : rmax, {V{1'b0}}};
                state_next = ST_RET;
            end
            ST_ROOT: begin
                ram_re     = 1'b1;
                ram_raddr  = NODE_W'(1);
                state_next = ST_ROOT_W;
            end
            ST_ROOT_W: begin
                root_next  = rmax;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (take) begin
                    item_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            item_reg  <= 1'b0;
            sp_reg    <= '0;
            sat_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            item_reg  <= item_next;
            sp_reg    <= sp_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        pend_reg <= pend_next;
        nmax_reg <= nmax_next;
        amax_reg <= amax_next;
        root_reg <= root_next;
        if (push_en) begin
            stk_node[sp_reg[IX_W-1:0]] <= node_reg;
            stk_lo[sp_reg[IX_W-1:0]]   <= lo_reg;
            stk_hi[sp_reg[IX_W-1:0]]   <= hi_reg;
            stk_ph[sp_reg[IX_W-1:0]]   <= push_ph;
        end
        if (set_right) begin
            stk_ph[tos] <= ragmt_pkg::PH_RIGHT;
        end
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign stat.sat  = sat_reg;
    assign root_max  = root_reg;
endmodule

>>> rtl/range_add_global_max_tree.sv
// Top level of the range add / global max lazy segment tree.
//
// Input channel (s_*): one item is either a clear (kind 0) or a range add of
// s_delta to leaves s_left_index..s_right_index. Each item yields exactly one
// result on the m_* channel: the root maximum, the running best since the
// last clear (never below zero) and a saturation flag for that item.
// Configuration (cfg_*): sets the number of leaves in use; write only while
// no item is in flight. cfg_ready is always high.
// A range add walks the tree depth first through the node memory. Each
// visited node is read and then evaluated; a pending add is pushed to its
// children before the walk descends, and on the way back the children's
// maxima are read and merged into the node. An empty or out-of-range add
// only reads the root.
// A clear sweeps all 4*LEAVES node entries, one per cycle, then reads the
// root. The same sweep runs after reset; s_ready stays low until it ends.
// One item is in work at a time. A finished result sits in the output
// register; the next item is accepted while it waits for m_ready, and the
// walker holds its own result until the output register is free.
module range_add_global_max_tree #(
    parameter int LEAVES     = ragmt_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = ragmt_pkg::VALUE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [ragmt_pkg::IDX_BITS-1:0]    s_left_index,
    input  logic [ragmt_pkg::IDX_BITS-1:0]    s_right_index,
    input  logic signed [ragmt_pkg::DELTA_BITS-1:0] s_delta,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [VALUE_BITS-1:0]      m_current_max,
    output logic [VALUE_BITS-2:0]             m_best_max,
    output logic                              m_saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ragmt_pkg::CFG_BITS-1:0]    cfg_leaves_in_use
);
`include "assert_macros.svh"

    localparam int V      = VALUE_BITS;
    localparam int DEPTH  = 4 * LEAVES;
    localparam int NODE_W = $clog2(DEPTH);
    localparam int LEAF_W = $clog2(LEAVES);
    localparam int NW     = (LEAF_W + 1 > ragmt_pkg::CFG_BITS) ? LEAF_W + 1
                                                               : ragmt_pkg::CFG_BITS;
    localparam int EW     = (V > ragmt_pkg::DELTA_BITS) ? V : ragmt_pkg::DELTA_BITS;
    localparam logic [EW-1:0] VMAX_E = {{(EW-V+1){1'b0}}, {(V-1){1'b1}}};
    localparam logic [EW-1:0] VMIN_E = ~VMAX_E;

    logic [ragmt_pkg::CFG_BITS-1:0] leaves_reg;
    logic [ragmt_pkg::IDX_BITS-1:0] left_reg, right_reg;
    logic signed [V-1:0] delta_reg, delta_clamp;
    logic signed [V-1:0] best_reg, best_next;
    logic m_valid_reg;
    logic signed [V-1:0] cur_reg;
    logic [V-2:0] bestout_reg;
    logic sat_out_reg;

    logic [NW-1:0] n_eff;
    logic [LEAF_W-1:0] top_hi;
    logic signed [EW-1:0] d_ext;
    logic dsat, accept, take;
    ragmt_pkg::walk_cmd_t cmd;
    ragmt_pkg::walk_stat_t stat;
    logic signed [V-1:0] root_max;

    logic ram_we, ram_re;
    logic [NODE_W-1:0] ram_waddr, ram_raddr;
    logic [2*V-1:0] ram_wdata, ram_rdata;

    // Leaf count: zero acts as one, anything above LEAVES acts as LEAVES.
    always_comb begin
        if (leaves_reg == '0) begin
            n_eff = NW'(1);
        end else if (NW'(leaves_reg) > NW'(LEAVES)) begin
            n_eff = NW'(LEAVES);
        end else begin
            n_eff = NW'(leaves_reg);
        end
    end
    assign top_hi = LEAF_W'(n_eff - 1'b1);

    // Clamp the delta into the node value range.
    assign d_ext = EW'(s_delta);
    always_comb begin
        dsat = 1'b0;
        delta_clamp = V'(d_ext);
        if (d_ext > $signed(VMAX_E)) begin
            dsat = 1'b1;
            delta_clamp = V'(VMAX_E);
        end else if (d_ext < $signed(VMIN_E)) begin
            dsat = 1'b1;
            delta_clamp = V'(VMIN_E);
        end
    end

    assign s_ready   = stat.idle;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign cmd.start     = accept;
    assign cmd.clear     = (s_kind == ragmt_pkg::KIND_CLEAR);
    assign cmd.range_ok  = (s_left_index <= s_right_index) && (NW'(s_right_index) < n_eff);
    assign cmd.delta_sat = (s_kind == ragmt_pkg::KIND_ADD) && dsat;

    // Hand the finished result over only when the output register is free.
    assign take = stat.done && (!m_valid_reg || m_ready);

    always_comb begin
        best_next = best_reg;
        if (accept && s_kind == ragmt_pkg::KIND_CLEAR) begin
            best_next = '0;
        end else if (take && root_max > best_reg) begin
            best_next = root_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leaves_reg  <= ragmt_pkg::CFG_RESET;
            best_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                leaves_reg <= cfg_leaves_in_use;
            end
            best_reg <= best_next;
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the item's operands for the walk and capture the result on hand-over.
    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg  <= s_left_index;
            right_reg <= s_right_index;
            delta_reg <= delta_clamp;
        end
        if (take) begin
            cur_reg     <= root_max;
            bestout_reg <= best_next[V-2:0];
            sat_out_reg <= stat.sat;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_current_max = cur_reg;
    assign m_best_max    = bestout_reg;
    assign m_saturated   = sat_out_reg;

    ragmt_walker #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .take      (take),
        .top_hi    (top_hi),
        .left_idx  (left_reg),
        .right_idx (right_reg),
        .delta_v   (delta_reg),
        .stat      (stat),
        .root_max  (root_max),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ragmt_node_ram #(
        .DEPTH (DEPTH),
        .WIDTH (2 * V)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One item at a time: the walker leaves idle right after an accept.
    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    // The running best never goes negative.
    `ASSERT_IMP(a_best_nonneg, aclk, aresetn, 1'b1, !best_reg[VALUE_BITS-1])
    // A result appears only after a finished walk.
    `ASSERT_IMP(a_result_src, aclk, aresetn, $rose(m_valid), $past(stat.done))
endmodule

>>> bench/range_add_global_max_tree_tb.sv
// Self-checking bench for the range add / global max lazy segment tree.
`timescale 1ns / 100ps

module range_add_global_max_tree_tb;
    import ragmt_pkg::*;

    localparam int  TREE_SIZE  = 4 * LEAVES_DEF;
    localparam longint VAL_TOP = (64'sd1 <<< (VALUE_BITS_DEF - 1)) - 1;
    localparam longint VAL_BOT = -VAL_TOP - 1;
    localparam int  STALL_LIMIT = 40000;

    // One expected answer of the block.
    typedef struct {
        logic [47:0] current_max;
        logic [46:0] best_max;
        logic        saturated;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = KIND_CLEAR;
    logic [IDX_BITS-1:0] s_left_index = '0;
    logic [IDX_BITS-1:0] s_right_index = '0;
    logic signed [DELTA_BITS-1:0] s_delta = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [47:0] m_current_max;
    logic [46:0] m_best_max;
    logic m_saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_BITS-1:0] cfg_leaves_in_use = CFG_RESET;

    range_add_global_max_tree i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_left_index      (s_left_index),
        .s_right_index     (s_right_index),
        .s_delta           (s_delta),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_current_max     (m_current_max),
        .m_best_max        (m_best_max),
        .m_saturated       (m_saturated),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_leaves_in_use (cfg_leaves_in_use)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Shadow tree: subtree maxima and pending adds, plus best and register copy.
    longint tree_max [TREE_SIZE];
    longint tree_pend [TREE_SIZE];
    longint best_seen;
    logic [CFG_BITS-1:0] leaf_reg;
    bit sat_seen;

    answer_t answers_due [$];
    int     error_count = 0;
    bit     idle_on = 1'b1;
    int     quiet_cycles = 0;

    // Clamp a sum to the signed 48-bit value range, flag any clamp.
    function automatic longint clamp_sum(longint a, longint d);
        if (d > 0 && a > VAL_TOP - d) begin
            sat_seen = 1'b1;
            return VAL_TOP;
        end
        if (d < 0 && a < VAL_BOT - d) begin
            sat_seen = 1'b1;
            return VAL_BOT;
        end
        return a + d;
    endfunction

    function automatic void bump_node(int node, longint d);
        if (node >= TREE_SIZE) return;
        tree_max[node]  = clamp_sum(tree_max[node], d);
        tree_pend[node] = clamp_sum(tree_pend[node], d);
    endfunction

    // Walk the tree: cover whole nodes, push pending adds down on the way.
    function automatic void add_over(int node, int lo, int hi, int l, int r, longint d);
        int mid;
        if (node >= TREE_SIZE) return;
        if (l <= lo && hi <= r) begin
            bump_node(node, d);
            return;
        end
        if (2 * node + 1 >= TREE_SIZE) return;
        if (tree_pend[node] != 0) begin
            bump_node(2 * node, tree_pend[node]);
            bump_node(2 * node + 1, tree_pend[node]);
            tree_pend[node] = 0;
        end
        mid = (lo + hi) >> 1;
        if (l <= mid) add_over(2 * node, lo, mid, l, r, d);
        if (r > mid) add_over(2 * node + 1, mid + 1, hi, l, r, d);
        tree_max[node] = (tree_max[2 * node] > tree_max[2 * node + 1]) ?
                         tree_max[2 * node] : tree_max[2 * node + 1];
    endfunction

    function automatic void wipe_tree();
        foreach (tree_max[i]) begin
            tree_max[i]  = 0;
            tree_pend[i] = 0;
        end
        best_seen = 0;
    endfunction

    // Leaf count as the block uses it: zero acts as one, large values cap.
    function automatic int leaves_now();
        if (leaf_reg == 0) return 1;
        if (leaf_reg > LEAVES_DEF) return LEAVES_DEF;
        return int'(leaf_reg);
    endfunction

    // Work out the answer to one accepted item and queue it.
    function automatic void predict_item(logic kind, int l, int r, logic signed [31:0] d);
        answer_t a;
        int n;
        n = leaves_now();
        sat_seen = 1'b0;
        if (kind == KIND_CLEAR) begin
            wipe_tree();
        end else if (l <= r && r < n) begin
            add_over(1, 0, n - 1, l, r, longint'(d));
        end
        if (tree_max[1] > best_seen) best_seen = tree_max[1];
        a.current_max = tree_max[1][47:0];
        a.best_max    = best_seen[46:0];
        a.saturated   = sat_seen;
        answers_due.push_back(a);
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    // Send one item; idle the input at random first, then hold until accepted.
    task automatic send_item(logic kind, int l, int r, logic signed [31:0] d);
        if (idle_on && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_left_index  <= l[IDX_BITS-1:0];
        s_right_index <= r[IDX_BITS-1:0];
        s_delta       <= d;
        do @(posedge aclk); while (!s_ready);
        predict_item(kind, l, r, d);
    endtask

    // Drain the results, then write the register while the block is idle.
    task automatic write_leaves(int value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid         <= 1'b1;
        cfg_leaves_in_use <= value[CFG_BITS-1:0];
        do @(posedge aclk); while (!cfg_ready);
        leaf_reg = value[CFG_BITS-1:0];
        cfg_valid <= 1'b0;
    endtask

    // Result side: stall at random, compare each item with the oldest answer.
    always @(posedge aclk) begin
        answer_t a;
        if (m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t result with no item pending", $time);
                error_count++;
            end else begin
                a = answers_due.pop_front();
                if (m_current_max !== a.current_max)
                    report_mismatch("current_max", m_current_max, a.current_max);
                if (m_best_max !== a.best_max)
                    report_mismatch("best_max", {1'b0, m_best_max}, {1'b0, a.best_max});
                if (m_saturated !== a.saturated)
                    report_mismatch("saturated", {47'b0, m_saturated},
                                    {47'b0, a.saturated});
            end
        end
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !(idle_on && $urandom_range(99) < 23);
    end

    // Watchdog: end the run when nothing has moved for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("range_add_global_max_tree_tb: errors");
            $finish;
        end
    end

    // Adds at the edges of the tree, empty and overhanging ranges, clears and leaf count changes.
    task automatic test_directed();
        send_item(KIND_ADD, 0, 1023, 32'sh7FFF_FFFF);
        send_item(KIND_ADD, 0, 1023, 32'sh8000_0000);
        send_item(KIND_ADD, 1023, 1023, 32'sd5);
        send_item(KIND_ADD, 0, 0, -32'sd7);
        send_item(KIND_ADD, 5, 4, 32'sd100);
        send_item(KIND_ADD, 1000, 1023, 32'sh7FFF_FFFF);
        send_item(KIND_ADD, 341, 682, 32'sd1);
        send_item(KIND_ADD, 512, 511, -32'sd1);
        send_item(KIND_CLEAR, 1023, 0, 32'sh7FFF_FFFF);
        send_item(KIND_ADD, 0, 1023, -32'sd3);
        send_item(KIND_ADD, 0, 0, 32'sd0);
        write_leaves(10);
        send_item(KIND_ADD, 3, 9, 32'sd11);
        send_item(KIND_ADD, 3, 10, 32'sd50);
        send_item(KIND_ADD, 9, 1023, 32'sd50);
        // shrink the tree without clearing: stale nodes get reused
        write_leaves(3);
        send_item(KIND_ADD, 0, 2, -32'sd4);
        send_item(KIND_ADD, 1, 1, 32'sd9);
        write_leaves(0);
        send_item(KIND_ADD, 0, 0, 32'sd17);
        send_item(KIND_ADD, 0, 1, 32'sd17);
        write_leaves(2047);
        send_item(KIND_ADD, 1023, 1023, 32'sd2);
        send_item(KIND_CLEAR, 0, 0, '0);
    endtask

    // Mostly well-formed ranges, some clears and some broken ranges.
    task automatic test_random_phase(int leaves, int count);
        int n, pick, l, r;
        logic signed [31:0] d;
        write_leaves(leaves);
        send_item(KIND_CLEAR, $urandom, $urandom, $urandom);
        n = leaves_now();
        repeat (count) begin
            pick = $urandom_range(99);
            d = $urandom;
            if ($urandom_range(3) != 0) d = $signed(d) >>> $urandom_range(31, 8);
            if (pick < 4) begin
                send_item(KIND_CLEAR, $urandom, $urandom, $urandom);
            end else if (pick < 12) begin
                send_item(KIND_ADD, $urandom_range(1023), $urandom_range(1023), d);
            end else begin
                l = $urandom_range(n - 1);
                r = $urandom_range(n - 1, l);
                send_item(KIND_ADD, l, r, d);
            end
        end
    endtask

    task automatic test_random();
        test_random_phase(1024, 300);
        test_random_phase(1, 60);
        test_random_phase(7, 150);
        // quiet stretch: no idling on either side
        idle_on = 1'b0;
        test_random_phase(1024, 200);
        idle_on = 1'b1;
        test_random_phase(513, 200);
        test_random_phase(2, 80);
        test_random_phase(1024, 150);
    endtask

    // Pile full-scale adds on one leaf, then pull it back with the most negative delta.
    task automatic test_full_scale();
        idle_on = 1'b0;
        write_leaves(1);
        send_item(KIND_CLEAR, 0, 0, '0);
        repeat (40) send_item(KIND_ADD, 0, 0, 32'sh7FFF_FFFF);
        send_item(KIND_ADD, 0, 0, 32'sh8000_0000);
        idle_on = 1'b1;
        send_item(KIND_CLEAR, 0, 0, '0);
    endtask

    initial begin
        wipe_tree();
        leaf_reg = CFG_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        test_full_scale();
        write_leaves(1024);
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (error_count == 0)
            $display("range_add_global_max_tree_tb: clean");
        else
            $display("range_add_global_max_tree_tb: errors");
        $finish;
    end
endmodule
